FILE: hdl/bounded_deque_with_stop_unit_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the bounded deque unit
// Clocked concurrent checks with active-low reset masking.
// ---------------------------------------------------------------------------
`ifndef BOUNDED_DEQUE_WITH_STOP_UNIT_ASSERT_SVH
`define BOUNDED_DEQUE_WITH_STOP_UNIT_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define BDQ_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bdq check failed");

// condition must never hold
`define BDQ_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("bdq forbidden condition");

`endif

FILE: hdl/bdq_pkg.sv
// ---------------------------------------------------------------------------
// Bounded deque package
// Shared widths, command and status codes, and the result word type.
// ---------------------------------------------------------------------------
package bdq_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int CMD_W     = 3;
    localparam int DATA_W    = 32;
    localparam int ST_W      = 2;
    localparam int CNT_W     = 7;
    localparam int CAP_W     = 7;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    localparam logic [CAP_W-1:0] CAP_RESET    = 7'd64;
    localparam logic             REG_CAPACITY = 1'b0;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_PEEK_FRONT = 3'd4,
        CMD_PEEK_BACK  = 3'd5,
        CMD_CLEAR      = 3'd6,
        CMD_STOP       = 3'd7
    } t_cmd;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_AGAIN = 2'd1,
        ST_EOS   = 2'd2
    } t_status;

    typedef struct packed {
        t_status            status;
        logic [DATA_W-1:0]  data;
        logic [CNT_W-1:0]   free_slots;
        logic [CNT_W-1:0]   used_count;
    } t_result;

endpackage

FILE: hdl/bdq_if.sv
// ---------------------------------------------------------------------------
// Bounded deque channel interfaces
// Command channel and result channel, valid/ready with payload.
// ---------------------------------------------------------------------------
interface bdq_cmd_if;
    logic                        valid;
    logic                        ready;
    logic [bdq_pkg::CMD_W-1:0]   cmd;
    logic [bdq_pkg::DATA_W-1:0]  handle;

    modport source (output valid, output cmd, output handle, input ready);
    modport sink   (input valid, input cmd, input handle, output ready);
endinterface

interface bdq_res_if;
    logic                        valid;
    logic                        ready;
    logic [bdq_pkg::ST_W-1:0]    status;
    logic [bdq_pkg::DATA_W-1:0]  data;
    logic [bdq_pkg::CNT_W-1:0]   free_slots;
    logic [bdq_pkg::CNT_W-1:0]   used_count;

    modport source (output valid, output status, output data, output free_slots,
                    output used_count, input ready);
    modport sink   (input valid, input status, input data, input free_slots,
                    input used_count, output ready);
endinterface

FILE: hdl/bounded_deque_with_stop_unit.sv
// ---------------------------------------------------------------------------
// Bounded deque with stop flag
// Double-ended queue of 32-bit handles with push, pop, peek, clear and stop.
// ---------------------------------------------------------------------------
// The unit takes one command word per clock while the result side keeps up and
// returns one result word per command, in order, via the core's result
// register, then the result queue. Each command is resolved combinationally
// against the front index, entry count and stop flag; the store is a
// single-write, single-read memory of DEPTH words whose registered read data
// joins the result in the following cycle, and a two-entry result queue lets
// commands keep flowing while a result waits. Sustained rate is one command
// per cycle without stalls. The capacity register limits the queue to
// min(capacity, DEPTH) entries and may be written only while the unit is idle.
module bounded_deque_with_stop_unit #(
    parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bdq_pkg::APB_AW-1:0]   paddr,
    input  logic [bdq_pkg::APB_DW-1:0]   pwdata,
    output logic [bdq_pkg::APB_DW-1:0]   prdata,
    output logic                         pready,
    bdq_cmd_if.sink                      i_cmd,
    bdq_res_if.source                    o_res
);

`include "bounded_deque_with_stop_unit_assert.svh"

    logic [bdq_pkg::CAP_W-1:0]  capacity;
    logic                       core_valid;
    logic                       q_ready;
    bdq_pkg::t_result           core_word;

    bdq_regs u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_capacity (capacity)
    );

    bdq_core #(
        .DEPTH (DEPTH)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_capacity (capacity),
        .i_cmd      (i_cmd),
        .o_valid    (core_valid),
        .o_word     (core_word),
        .i_ready    (q_ready)
    );

    bdq_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (core_valid),
        .i_word  (core_word),
        .o_ready (q_ready),
        .o_res   (o_res)
    );

    `BDQ_ASSERT_NEVER(a_fail_has_no_data, i_clk, i_rst_n, o_res.valid && (o_res.status != bdq_pkg::ST_OK) && (o_res.data != '0))
    `BDQ_ASSERT_IMPL(a_again_free_means_empty, i_clk, i_rst_n, o_res.valid && (o_res.status == bdq_pkg::ST_AGAIN) && (o_res.free_slots != '0), o_res.used_count == '0)
    `BDQ_ASSERT_IMPL(a_within_depth, i_clk, i_rst_n, o_res.valid, (32'(o_res.free_slots) + 32'(o_res.used_count)) <= 32'(DEPTH))

endmodule

FILE: hdl/bdq_regs.sv
// ---------------------------------------------------------------------------
// Bounded deque configuration registers
// APB-style access to the capacity register.
// ---------------------------------------------------------------------------
module bdq_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bdq_pkg::APB_AW-1:0]   paddr,
    input  logic [bdq_pkg::APB_DW-1:0]   pwdata,
    output logic [bdq_pkg::APB_DW-1:0]   prdata,
    output logic                         pready,
    output logic [bdq_pkg::CAP_W-1:0]    o_capacity
);

    logic                         reg_sel;
    logic [bdq_pkg::CAP_W-1:0]    r_capacity;

    assign reg_sel = (paddr[2] == bdq_pkg::REG_CAPACITY);
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= bdq_pkg::CAP_RESET;
        end else if (psel && penable && pwrite && reg_sel) begin
            r_capacity <= pwdata[bdq_pkg::CAP_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_sel) begin
            prdata = {{(bdq_pkg::APB_DW-bdq_pkg::CAP_W){1'b0}}, r_capacity};
        end
    end

    assign o_capacity = r_capacity;

endmodule

FILE: hdl/bdq_core.sv
// ---------------------------------------------------------------------------
// Bounded deque core: circular store with front index, count and stop flag;
// one command per cycle while the result queue accepts.
// ---------------------------------------------------------------------------
module bdq_core #(
    parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [bdq_pkg::CAP_W-1:0]   i_capacity,
    bdq_cmd_if.sink                     i_cmd,
    output logic                        o_valid,
    output bdq_pkg::t_result            o_word,
    input  logic                        i_ready
);

    localparam int AW = $clog2(DEPTH);
    localparam int SW = (AW + 1 > bdq_pkg::CNT_W) ? AW + 1 : bdq_pkg::CNT_W;

    logic [bdq_pkg::DATA_W-1:0]  r_mem [DEPTH];
    logic [bdq_pkg::DATA_W-1:0]  r_q;

    logic [AW-1:0]               r_front, n_front;
    logic [bdq_pkg::CNT_W-1:0]   r_count, n_count;
    logic                        r_stop, n_stop;

    logic                        r_a_valid;
    bdq_pkg::t_status            r_a_status, n_status;
    logic                        r_a_rd, n_rd;
    logic [bdq_pkg::CNT_W-1:0]   r_a_free, n_free;
    logic [bdq_pkg::CNT_W-1:0]   r_a_used;

    logic                        in_acc;
    logic                        a_take;
    logic                        we, re;
    logic [AW-1:0]               waddr, raddr;
    logic [bdq_pkg::CNT_W-1:0]   lim;
    logic [SW-1:0]               sum_new, sum_old;
    logic [AW-1:0]               back_new, back_old;
    logic [AW-1:0]               front_dec, front_inc;
    bdq_pkg::t_cmd               cmd;

    assign cmd     = bdq_pkg::t_cmd'(i_cmd.cmd);
    assign a_take  = r_a_valid && i_ready;
    assign i_cmd.ready = !r_a_valid || i_ready;
    assign in_acc  = i_cmd.valid && i_cmd.ready;

    assign lim = ({{(32-bdq_pkg::CAP_W){1'b0}}, i_capacity} < 32'(DEPTH)) ?
                 i_capacity : bdq_pkg::CNT_W'(DEPTH);

    assign sum_new  = SW'(r_front) + SW'(r_count);
    assign sum_old  = sum_new - SW'(1);
    assign back_new = (sum_new >= SW'(DEPTH)) ? AW'(sum_new - SW'(DEPTH)) : AW'(sum_new);
    assign back_old = (sum_old >= SW'(DEPTH)) ? AW'(sum_old - SW'(DEPTH)) : AW'(sum_old);
    assign front_dec = (r_front == '0) ? AW'(DEPTH - 1) : r_front - AW'(1);
    assign front_inc = (r_front == AW'(DEPTH - 1)) ? '0 : r_front + AW'(1);

    always_comb begin
        n_front  = r_front;
        n_count  = r_count;
        n_stop   = r_stop;
        n_status = bdq_pkg::ST_OK;
        n_rd     = 1'b0;
        we       = 1'b0;
        re       = 1'b0;
        waddr    = back_new;
        raddr    = r_front;
        case (cmd) inside
            bdq_pkg::CMD_PUSH_FRONT, bdq_pkg::CMD_PUSH_BACK: begin
                if (r_stop) begin
                    n_status = bdq_pkg::ST_EOS;
                end else if (r_count >= lim) begin
                    n_status = bdq_pkg::ST_AGAIN;
                end else begin
                    we      = 1'b1;
                    n_count = r_count + bdq_pkg::CNT_W'(1);
                    if (cmd == bdq_pkg::CMD_PUSH_FRONT) begin
                        n_front = front_dec;
                        waddr   = front_dec;
                    end
                end
            end
            bdq_pkg::CMD_POP_FRONT, bdq_pkg::CMD_POP_BACK,
            bdq_pkg::CMD_PEEK_FRONT, bdq_pkg::CMD_PEEK_BACK: begin
                if (r_count == '0) begin
                    n_status = r_stop ? bdq_pkg::ST_EOS : bdq_pkg::ST_AGAIN;
                end else begin
                    re   = 1'b1;
                    n_rd = 1'b1;
                    if (cmd == bdq_pkg::CMD_POP_FRONT || cmd == bdq_pkg::CMD_PEEK_FRONT) begin
                        raddr = r_front;
                        if (cmd == bdq_pkg::CMD_POP_FRONT) begin
                            n_front = front_inc;
                            n_count = r_count - bdq_pkg::CNT_W'(1);
                        end
                    end else begin
                        raddr = back_old;
                        if (cmd == bdq_pkg::CMD_POP_BACK) begin
                            n_count = r_count - bdq_pkg::CNT_W'(1);
                        end
                    end
                end
            end
            bdq_pkg::CMD_CLEAR: begin
                n_count = '0;
            end
            default: begin
                n_stop = 1'b1;
            end
        endcase
        n_free = (n_count < lim) ? lim - n_count : '0;
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && we) begin
            r_mem[waddr] <= i_cmd.handle;
        end
        if (in_acc && re) begin
            r_q <= r_mem[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front   <= '0;
            r_count   <= '0;
            r_stop    <= 1'b0;
            r_a_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_front <= n_front;
                r_count <= n_count;
                r_stop  <= n_stop;
            end
            if (in_acc) begin
                r_a_valid <= 1'b1;
            end else if (a_take) begin
                r_a_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a_status <= n_status;
            r_a_rd     <= n_rd;
            r_a_free   <= n_free;
            r_a_used   <= n_count;
        end
    end

    assign o_valid           = r_a_valid;
    assign o_word.status     = r_a_status;
    assign o_word.data       = r_a_rd ? r_q : '0;
    assign o_word.free_slots = r_a_free;
    assign o_word.used_count = r_a_used;

endmodule

FILE: hdl/bdq_outq.sv
// ---------------------------------------------------------------------------
// Bounded deque result queue
// Two-entry buffer that decouples the core from the result channel.
// ---------------------------------------------------------------------------
module bdq_outq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  bdq_pkg::t_result    i_word,
    output logic                o_ready,
    bdq_res_if.source           o_res
);

    bdq_pkg::t_result  r_buf [2];
    logic              r_wp, r_rp;
    logic [1:0]        r_cnt;
    logic              push, pop;

    assign o_ready = (r_cnt != 2'd2);
    assign push    = i_valid && o_ready;
    assign pop     = o_res.valid && o_res.ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wp] <= i_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    assign o_res.valid      = (r_cnt != 2'd0);
    assign o_res.status     = r_buf[r_rp].status;
    assign o_res.data       = r_buf[r_rp].data;
    assign o_res.free_slots = r_buf[r_rp].free_slots;
    assign o_res.used_count = r_buf[r_rp].used_count;

endmodule
